[design/xxtea_pkg.sv]
// Shared types, constants and functions of the XXTEA block cipher.
// Used by xxtea_ctrl, xxtea_dp and xxtea_block_cipher; depends on nothing.
`default_nettype none

package xxtea_pkg;

  // Store depth default and fixed widths
  localparam int unsigned MAX_WORDS_DEF = 64;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned ROUND_W       = 6;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned STATUS_W      = 2;

  localparam logic [WORD_W-1:0] XX_DELTA = 32'h9E37_79B9;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LONG  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR  = 3'd4;

  typedef logic [3:0][WORD_W-1:0] key_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_SETUP,
    S_SUM,
    S_RD,
    S_MX,
    S_WR,
    S_ORD,
    S_OUT,
    S_ERR
  } state_e;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;      // take one input word
    logic setup;     // prepare round count, index and neighbor words
    logic sum_init;  // load the running sum
    logic rd_nbr;    // fetch the neighbor word from the store
    logic mix;       // compute and hold the mix value
    logic wr;        // update the current word and advance
    logic rd_out;    // fetch a result word
    logic out_adv;   // result transaction taken, move on
  } ctrl_cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic blk_bad;   // closing word ends a block too short or too long
    logic final_wr;  // current update is the last one of the last round
    logic out_end;   // current result is the final word
  } dp_sts_t;

  // Full rounds for a block of n words: 6 + 52/n
  function automatic logic [ROUND_W-1:0] rounds_for(input logic [6:0] n);
    logic [ROUND_W-1:0] r;
    if (n <= 7'd2)       r = 6'd32;
    else if (n == 7'd3)  r = 6'd23;
    else if (n == 7'd4)  r = 6'd19;
    else if (n == 7'd5)  r = 6'd16;
    else if (n == 7'd6)  r = 6'd14;
    else if (n == 7'd7)  r = 6'd13;
    else if (n == 7'd8)  r = 6'd12;
    else if (n <= 7'd10) r = 6'd11;
    else if (n <= 7'd13) r = 6'd10;
    else if (n <= 7'd17) r = 6'd9;
    else if (n <= 7'd26) r = 6'd8;
    else if (n <= 7'd52) r = 6'd7;
    else                 r = 6'd6;
    return r;
  endfunction

  // XXTEA mixing function
  function automatic logic [WORD_W-1:0] mix(
    input logic [WORD_W-1:0] a,
    input logic [WORD_W-1:0] b,
    input logic [WORD_W-1:0] sum,
    input logic [1:0]        p,
    input key_t              key
  );
    logic [WORD_W-1:0] t1;
    logic [WORD_W-1:0] t2;
    logic [1:0]        ki;
    ki = p ^ sum[3:2];
    t1 = ((b >> 5) ^ (a << 2)) + ((a >> 3) ^ (b << 4));
    t2 = (sum ^ a) + (key[ki] ^ b);
    return t1 ^ t2;
  endfunction

endpackage

`default_nettype wire

[design/xxtea_ctrl.sv]
// Sequencing state machine of the XXTEA block cipher.
// Depends on xxtea_pkg; drives commands into xxtea_dp.
`default_nettype none

module xxtea_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  last_word_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire xxtea_pkg::dp_sts_t    sts_i,
  output xxtea_pkg::ctrl_cmd_t       cmd_o
);
  import xxtea_pkg::*;

  state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i && last_word_i) begin
          state_d = sts_i.blk_bad ? S_ERR : S_SETUP;
        end
      end
      S_SETUP: state_d = S_SUM;
      S_SUM:   state_d = S_RD;
      S_RD:    state_d = S_MX;
      S_MX:    state_d = S_WR;
      S_WR:    state_d = sts_i.final_wr ? S_ORD : S_RD;
      S_ORD:   state_d = S_OUT;
      S_OUT: begin
        if (out_ready_i) begin
          state_d = sts_i.out_end ? S_LOAD : S_ORD;
        end
      end
      S_ERR: begin
        if (out_ready_i) begin
          state_d = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o    = (state_q == S_LOAD);
    out_valid_o   = (state_q == S_OUT) || (state_q == S_ERR);
    cmd_o         = '0;
    cmd_o.load    = in_ready_o && in_valid_i;
    cmd_o.setup   = (state_q == S_SETUP);
    cmd_o.sum_init = (state_q == S_SUM);
    cmd_o.rd_nbr  = (state_q == S_RD);
    cmd_o.mix     = (state_q == S_MX);
    cmd_o.wr      = (state_q == S_WR);
    cmd_o.rd_out  = (state_q == S_ORD);
    cmd_o.out_adv = (state_q == S_OUT) && out_ready_i;
  end

endmodule

`default_nettype wire

[design/xxtea_dp.sv]
// Datapath of the XXTEA block cipher: word store, counters, sum and mix unit.
// Depends on xxtea_pkg; commanded by xxtea_ctrl.
`default_nettype none

module xxtea_dp #(
  parameter int unsigned MAX_WORDS = xxtea_pkg::MAX_WORDS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire xxtea_pkg::ctrl_cmd_t              cmd_i,
  output xxtea_pkg::dp_sts_t                     sts_o,
  input  wire logic [xxtea_pkg::WORD_W-1:0]      in_word_i,
  input  wire logic                              last_word_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [xxtea_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [xxtea_pkg::WORD_W-1:0]      cfg_wdata_i,
  output logic [xxtea_pkg::WORD_W-1:0]           out_word_o,
  output logic                                   out_last_o,
  output logic [xxtea_pkg::STATUS_W-1:0]         status_o
);
  import xxtea_pkg::*;

  localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_WORDS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_WORDS);

  // Configuration
  key_t key_q;
  logic dir_q;

  // Control state
  logic [CW-1:0]      cnt_q;
  logic               ovf_q;
  logic [AW-1:0]      idx_q;
  logic [AW-1:0]      last_idx_q;
  logic [ROUND_W-1:0] rounds_q;
  logic [STATUS_W-1:0] st_q;

  // Payload
  logic [WORD_W-1:0] mem_q [MAX_WORDS];
  logic [WORD_W-1:0] rd_q;
  logic [WORD_W-1:0] first_q, lastw_q;
  logic [WORD_W-1:0] sum_q, prev_q, cur_q, edge_q, nbr_q, mix_q;

  logic              enc_wrap, dec_wrap, round_end;
  logic              re;
  logic [AW-1:0]     ra, wa;
  logic              we;
  logic [WORD_W-1:0] wd, new_word, op_a, op_b;
  logic [6:0]        idx_ext, n_ext;

  assign enc_wrap  = (idx_q == last_idx_q);
  assign dec_wrap  = (idx_q == '0);
  assign round_end = dir_q ? dec_wrap : enc_wrap;
  assign idx_ext   = 7'(idx_q);
  assign n_ext     = 7'(last_idx_q) + 7'd1;

  // Status to the controller
  always_comb begin
    sts_o          = '0;
    sts_o.blk_bad  = ovf_q || (cnt_q == CNT_MAX) || (cnt_q == '0);
    sts_o.final_wr = round_end && (rounds_q == ROUND_W'(1));
    sts_o.out_end  = enc_wrap;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      dir_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY0: key_q[0] <= cfg_wdata_i;
        CFG_KEY1: key_q[1] <= cfg_wdata_i;
        CFG_KEY2: key_q[2] <= cfg_wdata_i;
        CFG_KEY3: key_q[3] <= cfg_wdata_i;
        CFG_DIR:  dir_q    <= cfg_wdata_i[0];
        default:  ;
      endcase
    end
  end

  // Mix operands: the wrap word stands in for the store at the block edge
  always_comb begin
    if (dir_q) begin
      op_a = prev_q;
      op_b = dec_wrap ? edge_q : rd_q;
    end else begin
      op_a = enc_wrap ? edge_q : rd_q;
      op_b = prev_q;
    end
  end

  assign new_word = dir_q ? (cur_q - mix_q) : (cur_q + mix_q);

  // Store port selection
  always_comb begin
    re = 1'b0;
    ra = idx_q;
    if (cmd_i.rd_out) begin
      re = 1'b1;
    end else if (cmd_i.rd_nbr) begin
      re = dir_q ? !dec_wrap : !enc_wrap;
      ra = dir_q ? (idx_q - AW'(1)) : (idx_q + AW'(1));
    end
    we = 1'b0;
    wa = idx_q;
    wd = new_word;
    if (cmd_i.load) begin
      we = (cnt_q != CNT_MAX);
      wa = AW'(cnt_q);
      wd = in_word_i;
    end else if (cmd_i.wr) begin
      we = 1'b1;
    end
  end

  // Word store
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem_q[ra];
    end
  end

  // Counters, index and rounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      idx_q      <= '0;
      last_idx_q <= '0;
      rounds_q   <= '0;
      st_q       <= ST_OK;
    end else begin
      if (cmd_i.load) begin
        if (last_word_i) begin
          cnt_q      <= '0;
          ovf_q      <= 1'b0;
          last_idx_q <= AW'(cnt_q);
          if (ovf_q || (cnt_q == CNT_MAX)) begin
            st_q <= ST_LONG;
          end else if (cnt_q == '0) begin
            st_q <= ST_SHORT;
          end else begin
            st_q <= ST_OK;
          end
        end else if (cnt_q == CNT_MAX) begin
          ovf_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CW'(1);
        end
      end
      if (cmd_i.setup) begin
        rounds_q <= rounds_for(n_ext);
        idx_q    <= dir_q ? last_idx_q : '0;
      end
      if (cmd_i.wr) begin
        if (round_end) begin
          rounds_q <= rounds_q - ROUND_W'(1);
          if (rounds_q == ROUND_W'(1)) begin
            idx_q <= '0;
          end else begin
            idx_q <= dir_q ? last_idx_q : '0;
          end
        end else begin
          idx_q <= dir_q ? (idx_q - AW'(1)) : (idx_q + AW'(1));
        end
      end
      if (cmd_i.out_adv && !enc_wrap) begin
        idx_q <= idx_q + AW'(1);
      end
    end
  end

  // Neighbor words, running sum and mix value
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (cnt_q == '0) begin
        first_q <= in_word_i;
      end
      if (last_word_i) begin
        lastw_q <= in_word_i;
      end
    end
    if (cmd_i.setup) begin
      prev_q <= dir_q ? first_q : lastw_q;
      cur_q  <= dir_q ? lastw_q : first_q;
    end
    if (cmd_i.sum_init) begin
      sum_q <= dir_q ? WORD_W'(WORD_W'(rounds_q) * XX_DELTA) : XX_DELTA;
    end
    if (cmd_i.mix) begin
      mix_q <= mix(op_a, op_b, sum_q, idx_ext[1:0], key_q);
      nbr_q <= dir_q ? op_b : op_a;
    end
    if (cmd_i.wr) begin
      prev_q <= new_word;
      cur_q  <= nbr_q;
      if (dir_q ? enc_wrap : dec_wrap) begin
        edge_q <= new_word;
      end
      if (round_end) begin
        sum_q <= dir_q ? (sum_q - XX_DELTA) : (sum_q + XX_DELTA);
      end
    end
  end

  // Result fields
  assign out_word_o = (st_q == ST_OK) ? rd_q : '0;
  assign out_last_o = (st_q != ST_OK) || enc_wrap;
  assign status_o   = st_q;

endmodule

`default_nettype wire

[design/xxtea_block_cipher.sv]
// Words load at one per cycle while in the load state; the closing word starts
// setup and sum load, then n * (6 + 52/n) updates: neighbor read, mix and write.
// Results leave one at a time (store read, then output), before new words load.
// A too short or too long block gives its single result in the next cycle.
// Reset clears control state and the key and direction registers; the word store
// is not cleared, only words of the current block are read.
`default_nettype none

module xxtea_block_cipher #(
  parameter int unsigned MAX_WORDS = xxtea_pkg::MAX_WORDS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [xxtea_pkg::WORD_W-1:0]      in_word_i,
  input  wire logic                              last_word_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [xxtea_pkg::WORD_W-1:0]           out_word_o,
  output logic                                   out_last_o,
  output logic [xxtea_pkg::STATUS_W-1:0]         status_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [xxtea_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [xxtea_pkg::WORD_W-1:0]      cfg_wdata_i
);
  import xxtea_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // Sequencer
  xxtea_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_word_i (last_word_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Store and arithmetic
  xxtea_dp #(
    .MAX_WORDS (MAX_WORDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_word_i   (in_word_i),
    .last_word_i (last_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_word_o  (out_word_o),
    .out_last_o  (out_last_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire

[sim/xxtea_result_checker.sv]
// Result checker for the XXTEA block cipher testbench: watches the register,
// input and output ports, predicts each block's results and compares them.
// Depends on xxtea_pkg for widths, status codes, register indexes and the delta.
module xxtea_result_checker #(
  parameter int unsigned MAX_WORDS = xxtea_pkg::MAX_WORDS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [xxtea_pkg::WORD_W-1:0]      in_word_i,
  input  logic                              last_word_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [xxtea_pkg::WORD_W-1:0]      out_word_i,
  input  logic                              out_last_i,
  input  logic [xxtea_pkg::STATUS_W-1:0]    status_i,
  input  logic                              cfg_we_i,
  input  logic [xxtea_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [xxtea_pkg::WORD_W-1:0]      cfg_wdata_i,
  output int                                pending_o,
  output int                                fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import xxtea_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0]   word;
    logic                last;
    logic [STATUS_W-1:0] status;
  } cipher_result_t;

  cipher_result_t    expected_results[$];
  logic [WORD_W-1:0] cipher_key[4];
  logic              decrypt_mode;
  logic [WORD_W-1:0] block_words[MAX_WORDS];
  int unsigned       words_held;
  logic              block_overrun;
  int                fails;

  // One XXTEA mixing step; y is the word after, z the word before
  function automatic logic [WORD_W-1:0] mix_value(
    input logic [WORD_W-1:0] y,
    input logic [WORD_W-1:0] z,
    input logic [WORD_W-1:0] sum,
    input int unsigned       pos
  );
    logic [1:0]        sel;
    logic [WORD_W-1:0] shifts;
    logic [WORD_W-1:0] keyed;
    sel    = pos[1:0] ^ sum[3:2];
    shifts = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    keyed  = (sum ^ y) + (cipher_key[sel] ^ z);
    return shifts ^ keyed;
  endfunction

  // Encrypt the first n held words in place
  function automatic void encipher_block(input int unsigned n);
    int unsigned       top;
    int unsigned       pos;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    top = n - 1;
    sum = '0;
    z   = block_words[top];
    repeat (6 + 52 / n) begin
      sum += XX_DELTA;
      for (pos = 0; pos < top; pos++) begin
        y = block_words[pos + 1];
        block_words[pos] += mix_value(y, z, sum, pos);
        z = block_words[pos];
      end
      y = block_words[0];
      block_words[top] += mix_value(y, z, sum, top);
      z = block_words[top];
    end
  endfunction

  // Decrypt the first n held words in place
  function automatic void decipher_block(input int unsigned n);
    int unsigned       top;
    int unsigned       pos;
    int unsigned       rounds;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    top    = n - 1;
    rounds = 6 + 52 / n;
    sum    = WORD_W'(rounds) * XX_DELTA;
    y      = block_words[0];
    repeat (rounds) begin
      for (pos = top; pos > 0; pos--) begin
        z = block_words[pos - 1];
        block_words[pos] -= mix_value(y, z, sum, pos);
        y = block_words[pos];
      end
      z = block_words[top];
      block_words[0] -= mix_value(y, z, sum, 0);
      y = block_words[0];
      sum -= XX_DELTA;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_result_t want;
    cipher_result_t got;
    int unsigned    n;
    int unsigned    i;
    if (!rst_ni) begin
      expected_results.delete();
      cipher_key    = '{default: '0};
      decrypt_mode  = 1'b0;
      words_held    = 0;
      block_overrun = 1'b0;
      fails         = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // Retire the oldest expectation on each output transaction
      if (out_valid_i && out_ready_i) begin
        got = '{word: out_word_i, last: out_last_i, status: status_i};
        if (expected_results.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word %h last %b status %0d", $time,
                   got.word, got.last, got.status);
        end else begin
          want = expected_results.pop_front();
          if (got.word !== want.word) begin
            fails++;
            $display("%0t: out_word expected %h, got %h", $time, want.word, got.word);
          end
          if (got.last !== want.last) begin
            fails++;
            $display("%0t: out_last expected %b, got %b", $time, want.last, got.last);
          end
          if (got.status !== want.status) begin
            fails++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
          end
        end
      end

      // Mirror register writes; unknown indexes are dropped
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_KEY0: cipher_key[0] = cfg_wdata_i;
          CFG_KEY1: cipher_key[1] = cfg_wdata_i;
          CFG_KEY2: cipher_key[2] = cfg_wdata_i;
          CFG_KEY3: cipher_key[3] = cfg_wdata_i;
          CFG_DIR:  decrypt_mode  = cfg_wdata_i[0];
          default: ;
        endcase
      end

      // Collect words; the closing word produces the block's results
      if (in_valid_i && in_ready_i) begin
        if (words_held < MAX_WORDS) begin
          block_words[words_held] = in_word_i;
          words_held++;
        end else begin
          block_overrun = 1'b1;
        end
        if (last_word_i) begin
          n          = words_held;
          words_held = 0;
          if (block_overrun || n < 2) begin
            expected_results.push_back('{word: '0, last: 1'b1,
                                         status: block_overrun ? ST_LONG : ST_SHORT});
            block_overrun = 1'b0;
          end else begin
            if (decrypt_mode) decipher_block(n);
            else encipher_block(n);
            for (i = 0; i < n; i++) begin
              expected_results.push_back('{word: block_words[i], last: (i == n - 1),
                                           status: ST_OK});
            end
          end
        end
      end

      pending_o    <= expected_results.size();
      fail_count_o <= fails;
    end
  end

endmodule

[sim/testbench.sv]
// Top of the XXTEA block cipher testbench: clock, reset, stimulus and verdict.
// Depends on xxtea_pkg, xxtea_block_cipher and xxtea_result_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import xxtea_pkg::*;

  localparam int unsigned MAX_WORDS    = MAX_WORDS_DEF;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned MAX_GAP      = 18;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef enum {FILL_ZERO, FILL_ONES, FILL_RAND, FILL_MIXED} fill_e;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [WORD_W-1:0]   in_word_i;
  logic                last_word_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [WORD_W-1:0]   out_word_o;
  logic                out_last_o;
  logic [STATUS_W-1:0] status_o;
  logic                cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [WORD_W-1:0]   cfg_wdata_i;

  int          pending_results;
  int          fail_count;
  bit          no_gaps;
  int          rx_hold_requests;
  int unsigned words_sent;

  xxtea_block_cipher #(.MAX_WORDS(MAX_WORDS)) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .last_word_i (last_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .out_last_o  (out_last_o),
    .status_o    (status_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  xxtea_result_checker #(.MAX_WORDS(MAX_WORDS)) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_word_i    (in_word_i),
    .last_word_i  (last_word_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_i   (out_word_o),
    .out_last_i   (out_last_o),
    .status_i     (status_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pending_o    (pending_results),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: random hold-off per result, plus long holds on request
  initial begin
    int unsigned gap;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (rx_hold_requests > 0) begin
        rx_hold_requests--;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      gap = no_gaps ? 0 : $urandom_range(MAX_GAP, 0);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic load_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                          input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3,
                          input logic [WORD_W-1:0] dir_word);
    write_reg(CFG_KEY0, k0);
    write_reg(CFG_KEY1, k1);
    write_reg(CFG_KEY2, k2);
    write_reg(CFG_KEY3, k3);
    write_reg(CFG_DIR, dir_word);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one word after a random gap and hold it until taken
  task automatic push_word(input logic [WORD_W-1:0] w, input logic is_last);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(MAX_GAP, 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_word_i   <= w;
    last_word_i <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_block(input int unsigned n, input fill_e fill);
    int unsigned       i;
    logic [WORD_W-1:0] w;
    for (i = 0; i < n; i++) begin
      case (fill)
        FILL_ZERO: w = '0;
        FILL_ONES: w = '1;
        FILL_RAND: w = $urandom();
        default:   w = ($urandom_range(7, 0) == 0) ? {WORD_W{$urandom_range(1, 0) == 1}}
                                                   : $urandom();
      endcase
      push_word(w, i == n - 1);
      words_sent++;
    end
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  task automatic settle();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int          phase;
    int unsigned target;
    int unsigned roll;
    int unsigned len;
    in_valid_i       <= 1'b0;
    in_word_i        <= '0;
    last_word_i      <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_KEY0;
    cfg_wdata_i      <= '0;
    rst_ni           <= 1'b0;
    no_gaps          = 1'b0;
    rx_hold_requests = 0;
    words_sent       = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset key: single-word blocks, extremes of two-word blocks, a random three-word block
    send_block(1, FILL_ZERO);
    send_block(1, FILL_ONES);
    send_block(2, FILL_ZERO);
    send_block(2, FILL_ONES);
    send_block(3, FILL_RAND);
    settle();

    // All-ones key; direction written with spare high bits; spare index ignored
    write_reg(CFG_SPARE, '1);
    load_key('1, '1, '1, '1, 32'hFFFF_FFFF);
    send_block(1, FILL_ZERO);
    send_block(2, FILL_ZERO);
    send_block(2, FILL_ONES);
    send_block(5, FILL_RAND);
    settle();

    // Direction bit cleared by a wide write that masks to encrypt
    load_key(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210, 32'h0000_0002);
    send_block(4, FILL_RAND);
    settle();

    // Random blocks over several key and direction settings
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: load_key('0, '0, '0, '0, 32'h0);
        1: load_key('1, '1, '1, '1, 32'h1);
        default: load_key($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      endcase
      no_gaps = (phase % 4 == 3) || (phase == 2);
      // Stall results long enough for the input to back up
      if (phase == 2) rx_hold_requests++;
      target = words_sent + 6;
      while (words_sent < target) begin
        roll = $urandom_range(99, 0);
        if (roll < 8) len = 1;
        else if (roll < 35) len = 2;
        else len = $urandom_range(12, 3);
        send_block(len, FILL_MIXED);
        if ($urandom_range(11, 0) == 0) wait_results();
      end
      settle();
    end

    // Full store, overrun, and recovery afterward
    no_gaps = 1'b0;
    load_key($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    send_block(MAX_WORDS, FILL_MIXED);
    send_block(MAX_WORDS + 2, FILL_MIXED);
    send_block(2, FILL_MIXED);
    send_block(1, FILL_MIXED);
    settle();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
